### sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// implication checked in the cycle after the antecedent, outside reset
`define CHK_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### sv/vscf_pkg.sv
// package with the types, codes and constants of the safety command block
package vscf_pkg;

    localparam int Channels = 8;
    localparam int ChW = (Channels > 1) ? $clog2(Channels) : 1;

    localparam logic [2:0] MODE_DISARMED = 3'd0;
    localparam logic [2:0] MODE_IDLE     = 3'd1;
    localparam logic [2:0] MODE_ACTIVE   = 3'd2;
    localparam logic [2:0] MODE_MANUAL   = 3'd3;
    localparam logic [2:0] MODE_COMMLOST = 3'd4;
    localparam logic [2:0] MODE_ESTOP    = 3'd5;

    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_NACK   = 2'd1;
    localparam logic [1:0] KIND_HB     = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    localparam logic [3:0] RSN_UNSUPPORTED = 4'd0;
    localparam logic [3:0] RSN_BAD_LEN     = 4'd1;
    localparam logic [3:0] RSN_BAD_STATE   = 4'd2;
    localparam logic [3:0] RSN_ESTOP       = 4'd3;
    localparam logic [3:0] RSN_NOT_ARMED   = 4'd4;
    localparam logic [3:0] RSN_BAD_CHANNEL = 4'd5;
    localparam logic [3:0] RSN_INVALID     = 4'd6;
    localparam logic [3:0] RSN_BAD_PWM     = 4'd7;
    localparam logic [3:0] RSN_BUSY        = 4'd8;

    localparam logic [4:0] CMD_NOP        = 5'd0;
    localparam logic [4:0] CMD_HEARTBEAT  = 5'd1;
    localparam logic [4:0] CMD_ARM        = 5'd2;
    localparam logic [4:0] CMD_DISARM     = 5'd3;
    localparam logic [4:0] CMD_ESTOP      = 5'd4;
    localparam logic [4:0] CMD_RESET_ESTOP = 5'd5;
    localparam logic [4:0] CMD_ENTER_MAN  = 5'd6;
    localparam logic [4:0] CMD_EXIT_MAN   = 5'd7;
    localparam logic [4:0] CMD_SET_PWM    = 5'd8;
    localparam logic [4:0] CMD_NEUTRAL    = 5'd9;
    localparam logic [4:0] CMD_FLOAT_ON   = 5'd10;
    localparam logic [4:0] CMD_FLOAT_OFF  = 5'd11;
    localparam logic [4:0] CMD_ANGLE_ON   = 5'd12;
    localparam logic [4:0] CMD_ANGLE_OFF  = 5'd13;
    localparam logic [4:0] CMD_DEPTH      = 5'd14;
    localparam logic [4:0] CMD_YAW        = 5'd15;
    localparam logic [4:0] CMD_MOTION     = 5'd16;
    localparam logic [4:0] CMD_BODY       = 5'd17;
    localparam logic [4:0] CMD_BODY_ON    = 5'd18;
    localparam logic [4:0] CMD_BODY_OFF   = 5'd19;
    localparam logic [4:0] CMD_TUNING     = 5'd20;
    localparam logic [4:0] CMD_STATUS     = 5'd21;
    localparam logic [4:0] CMD_SENSOR     = 5'd22;
    localparam logic [4:0] CMD_TUNE_REQ   = 5'd23;

    localparam logic [1:0] CFG_PWM_MIN = 2'd0;
    localparam logic [1:0] CFG_PWM_MAX = 2'd1;
    localparam logic [1:0] CFG_DEF_TMO = 2'd2;
    localparam logic [1:0] CFG_NEUTRAL = 2'd3;

    localparam logic [5:0] EN_CTL    = 6'h01;
    localparam logic [5:0] EN_FLOAT  = 6'h02;
    localparam logic [5:0] EN_ANGLE  = 6'h04;
    localparam logic [5:0] EN_MANUAL = 6'h08;
    localparam logic [5:0] EN_BODY   = 6'h20;

    localparam logic [1:0] NR_NONE    = 2'd0;
    localparam logic [1:0] NR_COMMAND = 2'd1;
    localparam logic [1:0] NR_DISARM  = 2'd2;
    localparam logic [1:0] NR_ESTOP   = 2'd3;

    localparam logic [7:0] NO_CHANNEL = 8'hFF;
    localparam int QDepth = 2;

    typedef struct packed {
        logic [4:0]  req_type;
        logic [15:0] sequence_req;
        logic [31:0] now_ms;
        logic        payload_ok;
        logic        value_ok;
        logic [7:0]  pwm_channel;
        logic [7:0]  pwm_reserved;
        logic signed [15:0] pwm_us;
        logic [15:0] pwm_timeout_ms;
        logic [7:0]  motion_code;
        logic [15:0] hb_window_ms;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] echo_sequence;
        logic [4:0]  nack_type;
        logic [3:0]  nack_reason;
        logic [2:0]  safety_mode;
        logic [5:0]  flags;
        logic [7:0]  test_chan;
        logic [15:0] nack_total;
        logic        state_changed;
    } rsp_t;

    // classified command passed from the front to the back
    typedef struct packed {
        logic [4:0]  req_type;
        logic [15:0] sequence_req;
        logic [31:0] now_ms;
        logic        drop;
        logic        pre_nack;
        logic [3:0]  pre_reason;
        logic        val_ok;
        logic        motion_ok;
        logic [7:0]  ch;
        logic [15:0] pwm_raw;
        logic [10:0] tmo;
        logic [15:0] hbt;
    } cmd_t;

endpackage

### sv/vscf_if.sv
// valid/ready channel carrying one word of a given type
interface vscf_if #(parameter type word_t = logic) (input logic clk);
    logic  valid;
    logic  ready;
    word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/vscf_front.sv
// front stage: stateless checks of type, length and payload ranges
module vscf_front (
    input  vscf_pkg::req_t    req,
    input  logic [15:0]       pwm_min_us,
    input  logic [15:0]       pwm_max_us,
    input  logic [10:0]       def_tmo,
    output vscf_pkg::cmd_t    cmd
);
    import vscf_pkg::*;

    logic signed [16:0] pw_s;
    logic [15:0] tmo_eff;

    always_comb
    begin
        pw_s = {req.pwm_us[15], req.pwm_us};
        tmo_eff = (req.pwm_timeout_ms == 16'd0) ? {5'd0, def_tmo} : req.pwm_timeout_ms;
        cmd = '0;
        cmd.req_type = req.req_type;
        cmd.sequence_req = req.sequence_req;
        cmd.now_ms = req.now_ms;
        cmd.val_ok = req.value_ok;
        cmd.motion_ok = (req.motion_code <= 8'd7);
        cmd.ch = req.pwm_channel;
        cmd.pwm_raw = req.pwm_us;
        cmd.tmo = tmo_eff[10:0];
        cmd.hbt = req.hb_window_ms;
        if (req.req_type > CMD_TUNE_REQ)
        begin
            cmd.pre_nack = 1'b1;
            cmd.pre_reason = RSN_UNSUPPORTED;
        end
        else if (!req.payload_ok)
        begin
            cmd.pre_nack = 1'b1;
            cmd.pre_reason = RSN_BAD_LEN;
        end
        else if (req.req_type == CMD_SENSOR || req.req_type == CMD_TUNE_REQ)
        begin
            cmd.drop = 1'b1;
        end
        else if (req.req_type == CMD_HEARTBEAT &&
                 (req.hb_window_ms < 16'd200 || req.hb_window_ms > 16'd5000))
        begin
            cmd.pre_nack = 1'b1;
            cmd.pre_reason = RSN_INVALID;
        end
        else if (req.req_type == CMD_SET_PWM)
        begin
            if (req.pwm_channel >= 8'(Channels))
            begin
                cmd.pre_nack = 1'b1;
                cmd.pre_reason = RSN_BAD_CHANNEL;
            end
            else if (req.pwm_reserved != 8'd0)
            begin
                cmd.pre_nack = 1'b1;
                cmd.pre_reason = RSN_INVALID;
            end
            else if (pw_s < $signed({1'b0, pwm_min_us}) || pw_s > $signed({1'b0, pwm_max_us}))
            begin
                cmd.pre_nack = 1'b1;
                cmd.pre_reason = RSN_BAD_PWM;
            end
            else if (tmo_eff < 16'd200 || tmo_eff > 16'd2000)
            begin
                cmd.pre_nack = 1'b1;
                cmd.pre_reason = RSN_INVALID;
            end
        end
        else if ((req.req_type == CMD_DEPTH || req.req_type == CMD_YAW ||
                  req.req_type == CMD_TUNING) && !req.value_ok)
        begin
            cmd.pre_nack = 1'b1;
            cmd.pre_reason = RSN_INVALID;
        end
    end
endmodule

### sv/vscf_queue.sv
// short queue between the front and back stages
module vscf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  vscf_pkg::cmd_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output vscf_pkg::cmd_t out_data
);
    import vscf_pkg::*;

    cmd_t mem_reg [QDepth];
    logic wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic push, pop;

    assign in_ready = (count_reg != 2'(QDepth));
    assign out_valid = (count_reg != 2'd0);
    assign out_data = mem_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

### sv/vscf_back.sv
// back stage: applies commands to the safety state and registers the result
module vscf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  vscf_pkg::cmd_t cmd,
    input  logic [15:0]    neutral_us,
    output logic           out_valid,
    input  logic           out_ready,
    output vscf_pkg::rsp_t rsp
);
    import vscf_pkg::*;

    logic [2:0]  mode_reg, mode_next;
    logic        est_reg, est_next;
    logic [5:0]  en_reg, en_next;
    logic        bcv_reg, bcv_next;
    logic [15:0] pulse_reg [Channels];
    logic [7:0]  tch_reg, tch_next;
    logic [31:0] tdl_reg, tdl_next;
    logic [1:0]  nr_reg, nr_next;
    logic [15:0] err_reg, err_next;
    logic [15:0] hbt_reg, hbt_next;
    logic [31:0] hbl_reg, hbl_next;
    logic [31:0] mca_reg, mca_next;
    logic        neut;
    logic        pulse_wr;
    logic        nack;
    logic [3:0]  rsn;
    logic [1:0]  kind;
    logic        ovalid_reg;
    rsp_t        rsp_reg, rsp_next;
    logic        fire;
    logic        ok;

    assign in_ready = !ovalid_reg || out_ready;
    assign fire = in_valid && in_ready;
    assign out_valid = ovalid_reg;
    assign rsp = rsp_reg;

    always_comb
    begin
        mode_next = mode_reg;
        est_next = est_reg;
        en_next = en_reg;
        bcv_next = bcv_reg;
        tch_next = tch_reg;
        tdl_next = tdl_reg;
        nr_next = nr_reg;
        err_next = err_reg;
        hbt_next = hbt_reg;
        hbl_next = hbl_reg;
        neut = 1'b0;
        pulse_wr = 1'b0;
        nack = cmd.pre_nack;
        rsn = cmd.pre_reason;
        kind = KIND_ACK;
        ok = 1'b0;
        if (cmd.pre_nack)
        begin
            if (cmd.pre_reason == RSN_BAD_LEN &&
                (cmd.req_type == CMD_MOTION || cmd.req_type == CMD_BODY))
            begin
                neut = 1'b1;
                nr_next = est_reg ? NR_ESTOP : NR_COMMAND;
                en_next = en_reg & ~(EN_CTL | EN_FLOAT | EN_ANGLE);
                if (!est_reg && mode_reg == MODE_ACTIVE)
                begin
                    mode_next = MODE_IDLE;
                end
            end
        end
        else
        begin
            unique case (cmd.req_type)
                CMD_HEARTBEAT:
                begin
                    hbt_next = cmd.hbt;
                    hbl_next = cmd.now_ms;
                    if (mode_reg == MODE_COMMLOST)
                    begin
                        mode_next = MODE_DISARMED;
                    end
                    kind = KIND_HB;
                end
                CMD_ARM:
                begin
                    if (est_reg || mode_reg == MODE_ESTOP)
                    begin
                        nack = 1'b1;
                        rsn = RSN_ESTOP;
                    end
                    else if (mode_reg == MODE_DISARMED || mode_reg == MODE_COMMLOST)
                    begin
                        en_next = en_reg & ~(EN_CTL | EN_FLOAT | EN_ANGLE);
                        neut = 1'b1;
                        nr_next = NR_NONE;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        nack = 1'b1;
                        rsn = RSN_BAD_STATE;
                    end
                end
                CMD_DISARM:
                begin
                    en_next = en_reg & ~(EN_CTL | EN_FLOAT | EN_ANGLE);
                    neut = 1'b1;
                    nr_next = est_reg ? NR_ESTOP : NR_DISARM;
                    mode_next = est_reg ? MODE_ESTOP : MODE_DISARMED;
                end
                CMD_ESTOP:
                begin
                    en_next = en_reg & ~(EN_CTL | EN_FLOAT | EN_ANGLE);
                    est_next = 1'b1;
                    neut = 1'b1;
                    nr_next = NR_ESTOP;
                    mode_next = MODE_ESTOP;
                end
                CMD_RESET_ESTOP:
                begin
                    if (est_reg && mode_reg == MODE_ESTOP)
                    begin
                        est_next = 1'b0;
                        neut = 1'b1;
                        nr_next = NR_DISARM;
                        mode_next = MODE_DISARMED;
                    end
                    else
                    begin
                        nack = 1'b1;
                        rsn = RSN_BAD_STATE;
                    end
                end
                CMD_ENTER_MAN:
                begin
                    if (!est_reg && mode_reg == MODE_IDLE)
                    begin
                        en_next = en_reg & ~(EN_CTL | EN_FLOAT | EN_ANGLE);
                        neut = 1'b1;
                        nr_next = NR_NONE;
                        mode_next = MODE_MANUAL;
                    end
                    else
                    begin
                        nack = 1'b1;
                        rsn = RSN_BAD_STATE;
                    end
                end
                CMD_EXIT_MAN:
                begin
                    if (mode_reg == MODE_MANUAL)
                    begin
                        neut = 1'b1;
                        nr_next = NR_COMMAND;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        nack = 1'b1;
                        rsn = RSN_BAD_STATE;
                    end
                end
                CMD_SET_PWM:
                begin
                    if (est_reg)
                    begin
                        nack = 1'b1;
                        rsn = RSN_ESTOP;
                    end
                    else if (mode_reg != MODE_MANUAL)
                    begin
                        nack = 1'b1;
                        rsn = RSN_NOT_ARMED;
                    end
                    else if (tch_reg != NO_CHANNEL && tch_reg != cmd.ch)
                    begin
                        nack = 1'b1;
                        rsn = RSN_BUSY;
                    end
                    else
                    begin
                        tch_next = cmd.ch;
                        tdl_next = cmd.now_ms + {21'd0, cmd.tmo};
                        pulse_wr = 1'b1;
                        en_next = en_reg | EN_MANUAL;
                        nr_next = NR_NONE;
                    end
                end
                CMD_NEUTRAL:
                begin
                    en_next = en_reg & ~(EN_CTL | EN_FLOAT | EN_ANGLE);
                    neut = 1'b1;
                    nr_next = est_reg ? NR_ESTOP : NR_COMMAND;
                    if (!est_reg && (mode_reg == MODE_MANUAL || mode_reg == MODE_ACTIVE))
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
                CMD_FLOAT_ON:
                begin
                    if (!est_reg && (mode_reg == MODE_IDLE || mode_reg == MODE_ACTIVE))
                    begin
                        en_next = (en_reg | EN_FLOAT | EN_CTL) & ~EN_MANUAL;
                        tch_next = NO_CHANNEL;
                        bcv_next = 1'b0;
                        nr_next = NR_NONE;
                        mode_next = MODE_ACTIVE;
                    end
                    else
                    begin
                        nack = 1'b1;
                        rsn = RSN_BAD_STATE;
                    end
                end
                CMD_FLOAT_OFF, CMD_ANGLE_OFF:
                begin
                    if (mode_reg == MODE_ACTIVE)
                    begin
                        if (cmd.req_type == CMD_FLOAT_OFF)
                        begin
                            en_next = en_reg & ~EN_FLOAT;
                            bcv_next = 1'b0;
                            ok = (en_reg & (EN_ANGLE | EN_BODY)) == 6'd0;
                        end
                        else
                        begin
                            en_next = en_reg & ~EN_ANGLE;
                            ok = (en_reg & (EN_FLOAT | EN_BODY)) == 6'd0;
                        end
                        if (ok)
                        begin
                            en_next = en_next & ~EN_CTL;
                            neut = 1'b1;
                            nr_next = NR_COMMAND;
                            mode_next = MODE_IDLE;
                        end
                    end
                    else
                    begin
                        nack = 1'b1;
                        rsn = RSN_BAD_STATE;
                    end
                end
                CMD_ANGLE_ON:
                begin
                    if (!est_reg && (mode_reg == MODE_IDLE || mode_reg == MODE_ACTIVE))
                    begin
                        en_next = en_reg | EN_ANGLE | EN_CTL;
                        nr_next = NR_NONE;
                        mode_next = MODE_ACTIVE;
                    end
                    else
                    begin
                        nack = 1'b1;
                        rsn = RSN_BAD_STATE;
                    end
                end
                CMD_DEPTH:
                begin
                    if (!(mode_reg == MODE_ACTIVE && (en_reg & (EN_BODY | EN_FLOAT)) != 6'd0
                          && !est_reg))
                    begin
                        nack = 1'b1;
                        rsn = RSN_BAD_STATE;
                    end
                end
                CMD_YAW:
                begin
                    if (mode_reg == MODE_ACTIVE && !est_reg)
                    begin
                        en_next = en_reg | EN_ANGLE | EN_CTL;
                    end
                    else
                    begin
                        nack = 1'b1;
                        rsn = RSN_BAD_STATE;
                    end
                end
                CMD_MOTION, CMD_BODY:
                begin
                    if (cmd.req_type == CMD_MOTION)
                    begin
                        ok = mode_reg == MODE_ACTIVE && en_reg[0] &&
                             (en_reg & (EN_FLOAT | EN_BODY)) != 6'd0 && !est_reg;
                    end
                    else
                    begin
                        ok = mode_reg == MODE_ACTIVE && en_reg[5] && en_reg[0] && !est_reg;
                    end
                    if ((cmd.req_type == CMD_MOTION) ? !cmd.motion_ok : !cmd.val_ok)
                    begin
                        nack = 1'b1;
                        rsn = RSN_INVALID;
                        ok = 1'b0;
                    end
                    else if (!ok)
                    begin
                        nack = 1'b1;
                        rsn = RSN_BAD_STATE;
                    end
                    if (ok)
                    begin
                        bcv_next = 1'b1;
                        nr_next = NR_NONE;
                    end
                    else
                    begin
                        neut = 1'b1;
                        nr_next = est_reg ? NR_ESTOP : NR_COMMAND;
                        en_next = en_reg & ~(EN_CTL | EN_FLOAT | EN_ANGLE);
                        if (!est_reg && mode_reg == MODE_ACTIVE)
                        begin
                            mode_next = MODE_IDLE;
                        end
                    end
                end
                CMD_BODY_ON:
                begin
                    if (!est_reg && mode_reg == MODE_IDLE)
                    begin
                        en_next = (en_reg | EN_CTL | EN_BODY) & ~(EN_FLOAT | EN_ANGLE);
                        bcv_next = 1'b0;
                        nr_next = NR_NONE;
                        mode_next = MODE_ACTIVE;
                    end
                    else
                    begin
                        nack = 1'b1;
                        rsn = est_reg ? RSN_ESTOP : RSN_BAD_STATE;
                    end
                end
                CMD_BODY_OFF:
                begin
                    if (mode_reg == MODE_ACTIVE && en_reg[5])
                    begin
                        en_next = en_reg & ~(EN_CTL | EN_FLOAT | EN_ANGLE | EN_BODY);
                        bcv_next = 1'b0;
                        nr_next = NR_COMMAND;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        nack = 1'b1;
                        rsn = RSN_BAD_STATE;
                    end
                end
                CMD_TUNING:
                begin
                    if (est_reg || !(mode_reg == MODE_DISARMED || mode_reg == MODE_IDLE))
                    begin
                        nack = 1'b1;
                        rsn = est_reg ? RSN_ESTOP : RSN_BAD_STATE;
                    end
                end
                CMD_STATUS:
                begin
                    kind = KIND_STATUS;
                end
                default:
                begin
                end
            endcase
        end
        if (neut)
        begin
            bcv_next = 1'b0;
            en_next = en_next & ~(EN_MANUAL | EN_BODY);
            tch_next = NO_CHANNEL;
        end
        if (nack)
        begin
            kind = KIND_NACK;
            if (err_reg != 16'hFFFF)
            begin
                err_next = err_reg + 16'd1;
            end
        end
        mca_next = (mode_next != mode_reg) ? cmd.now_ms : mca_reg;
        rsp_next.kind = kind;
        rsp_next.echo_sequence = cmd.sequence_req;
        rsp_next.nack_type = nack ? cmd.req_type : 5'd0;
        rsp_next.nack_reason = nack ? rsn : RSN_UNSUPPORTED;
        rsp_next.safety_mode = mode_next;
        rsp_next.flags = (en_next & 6'h2F) | (est_next ? 6'h10 : 6'h00);
        rsp_next.test_chan = tch_next;
        rsp_next.nack_total = err_next;
        rsp_next.state_changed = (mode_next != mode_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < Channels; i++)
            begin
                pulse_reg[i] <= 16'd1500;
            end
        end
        else if (fire && !cmd.drop)
        begin
            for (int i = 0; i < Channels; i++)
            begin
                if (neut)
                begin
                    pulse_reg[i] <= neutral_us;
                end
                else if (pulse_wr && cmd.ch[ChW-1:0] == ChW'(i))
                begin
                    pulse_reg[i] <= cmd.pwm_raw;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && !cmd.drop)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_DISARMED;
            est_reg <= 1'b0;
            en_reg <= 6'd0;
            bcv_reg <= 1'b0;
            tch_reg <= NO_CHANNEL;
            tdl_reg <= 32'd0;
            nr_reg <= NR_NONE;
            err_reg <= 16'd0;
            hbt_reg <= 16'd1000;
            hbl_reg <= 32'd0;
            mca_reg <= 32'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
            if (fire && !cmd.drop)
            begin
                mode_reg <= mode_next;
                est_reg <= est_next;
                en_reg <= en_next;
                bcv_reg <= bcv_next;
                tch_reg <= tch_next;
                tdl_reg <= tdl_next;
                nr_reg <= nr_next;
                err_reg <= err_next;
                hbt_reg <= hbt_next;
                hbl_reg <= hbl_next;
                mca_reg <= mca_next;
                ovalid_reg <= 1'b1;
            end
        end
    end
endmodule

### sv/vehicle_safety_command_fsm.sv
// top level of the vehicle safety command block
// channels: req (sink) takes one decoded command word, rsp (source) gives
// one answer word per command; sensor and tuning requests of valid length give no answer
// cfg_we/cfg_index/cfg_data write the pulse limits, default timeout and
// neutral pulse width; write only while no command is in flight
// the front stage checks type, length and payload ranges without state
// and writes a two-entry queue; the back stage applies the word to the
// safety state and loads the answer register
// the queue registers an accepted command, then the back stage loads the answer register
// throughput: one command per cycle while the receiver takes every answer
// a stalled rsp holds the answer; the queue absorbs two more commands,
// after which req ready drops until the receiver takes the answer
// reset: mode disarmed, latches and flags clear, no active channel,
// error count zero, every channel pulse at 1500 us, registers at
// 1100, 1900, 1000 and 1500
module vehicle_safety_command_fsm (
    input  logic        clk,
    input  logic        rst_n,
    vscf_if.sink        req,
    vscf_if.source      rsp,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import vscf_pkg::*;

    logic [15:0] pwm_min_reg, pwm_max_reg, neutral_reg;
    logic [10:0] def_tmo_reg;
    cmd_t        front_cmd, q_cmd;
    logic        q_valid, q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_min_reg <= 16'd1100;
            pwm_max_reg <= 16'd1900;
            def_tmo_reg <= 11'd1000;
            neutral_reg <= 16'd1500;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PWM_MIN: pwm_min_reg <= cfg_data;
                CFG_PWM_MAX: pwm_max_reg <= cfg_data;
                CFG_DEF_TMO: def_tmo_reg <= cfg_data[10:0];
                CFG_NEUTRAL: neutral_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    vscf_front u_front (
        .req        (req.data),
        .pwm_min_us (pwm_min_reg),
        .pwm_max_us (pwm_max_reg),
        .def_tmo    (def_tmo_reg),
        .cmd        (front_cmd)
    );

    vscf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_data   (front_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_cmd)
    );

    vscf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .cmd        (q_cmd),
        .neutral_us (neutral_reg),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .rsp        (rsp.data)
    );
endmodule

### sv/vscf_checker.sv
// port-level checker for the safety command block and its bind
`include "assert_macros.svh"
module vscf_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input vscf_pkg::rsp_t rsp_data
);
    import vscf_pkg::*;

    `CHK_IMPLY(a_nack_has_type, clk, rst_n, rsp_valid && rsp_data.kind != KIND_NACK,
        rsp_data.nack_type == 5'd0 && rsp_data.nack_reason == 4'd0, "stray nack fields")
    `CHK_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data),
        "answer changed while stalled")
    `CHK_IMPLY(a_estop_flag, clk, rst_n, rsp_valid && rsp_data.safety_mode == MODE_ESTOP,
        rsp_data.flags[4], "estop mode without latch")
    `CHK_IMPLY(a_idle_chan, clk, rst_n, rsp_valid && rsp_data.safety_mode != MODE_MANUAL,
        rsp_data.test_chan == NO_CHANNEL, "test channel outside manual")
    `CHK_IMPLY(a_full_stall, clk, rst_n, req_valid && !req_ready, rsp_valid,
        "input blocked with no answer waiting")
endmodule

bind vehicle_safety_command_fsm vscf_checker u_vscf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

### sim/testbench.sv
// testbench for the vehicle safety command block: random and directed commands against a predictor
`timescale 1ns / 1ps

module testbench;
    import vscf_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    vscf_if #(.word_t(req_t)) req_ch (clk);
    vscf_if #(.word_t(rsp_t)) rsp_ch (clk);

    vehicle_safety_command_fsm uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch.sink),
        .rsp       (rsp_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [15:0] lim_min, lim_max, def_tmo, neutral_us;
    logic [2:0]  cur_mode;
    logic        latched;
    logic [5:0]  en_bits;
    logic [7:0]  test_ch;
    logic [15:0] err_cnt;

    req_t cmd_backlog[$];
    rsp_t answers_due[$];
    int   error_total = 0;
    int   gap_left = 0;
    int   burst_left = 1;
    bit   flat_out = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic bit go_mode(logic [2:0] m);
        if (cur_mode == m)
            return 1'b0;
        cur_mode = m;
        return 1'b1;
    endfunction

    function automatic void neutralize();
        en_bits &= ~(EN_MANUAL | EN_BODY);
        test_ch = NO_CHANNEL;
    endfunction

    function automatic void clear_ctl();
        en_bits &= ~(EN_CTL | EN_FLOAT | EN_ANGLE);
    endfunction

    function automatic bit drop_motion();
        neutralize();
        clear_ctl();
        if (!latched && cur_mode == MODE_ACTIVE)
            return go_mode(MODE_IDLE);
        return 1'b0;
    endfunction

    function automatic bit predict_answer(input req_t r, output rsp_t o);
        logic [1:0] kind;
        int         reason;
        bit         chg;
        bit         est;
        int         pw;
        int         tmo;
        bit         good;
        bit         ok;
        logic [5:0] mine;
        logic [5:0] other;
        kind = KIND_ACK;
        reason = -1;
        chg = 1'b0;
        est = latched;
        pw = int'(r.pwm_us);
        tmo = int'(r.pwm_timeout_ms);
        o = '0;
        if (r.req_type > CMD_TUNE_REQ) begin
            reason = RSN_UNSUPPORTED;
        end
        else if (!r.payload_ok) begin
            if (r.req_type == CMD_MOTION || r.req_type == CMD_BODY)
                chg = drop_motion();
            reason = RSN_BAD_LEN;
        end
        else begin
            case (r.req_type)
                CMD_NOP: ;
                CMD_HEARTBEAT:
                    if (r.hb_window_ms < 200 || r.hb_window_ms > 5000)
                        reason = RSN_INVALID;
                    else
                    begin
                        if (cur_mode == MODE_COMMLOST)
                            chg = go_mode(MODE_DISARMED);
                        kind = KIND_HB;
                    end
                CMD_ARM:
                    if (est || cur_mode == MODE_ESTOP)
                        reason = RSN_ESTOP;
                    else if (cur_mode == MODE_DISARMED || cur_mode == MODE_COMMLOST)
                    begin
                        clear_ctl();
                        neutralize();
                        chg = go_mode(MODE_IDLE);
                    end
                    else
                        reason = RSN_BAD_STATE;
                CMD_DISARM:
                begin
                    clear_ctl();
                    neutralize();
                    chg = go_mode(est ? MODE_ESTOP : MODE_DISARMED);
                end
                CMD_ESTOP:
                begin
                    clear_ctl();
                    latched = 1'b1;
                    neutralize();
                    chg = go_mode(MODE_ESTOP);
                end
                CMD_RESET_ESTOP:
                    if (est && cur_mode == MODE_ESTOP)
                    begin
                        latched = 1'b0;
                        neutralize();
                        chg = go_mode(MODE_DISARMED);
                    end
                    else
                        reason = RSN_BAD_STATE;
                CMD_ENTER_MAN:
                    if (!est && cur_mode == MODE_IDLE)
                    begin
                        clear_ctl();
                        neutralize();
                        chg = go_mode(MODE_MANUAL);
                    end
                    else
                        reason = RSN_BAD_STATE;
                CMD_EXIT_MAN:
                    if (cur_mode == MODE_MANUAL)
                    begin
                        neutralize();
                        chg = go_mode(MODE_IDLE);
                    end
                    else
                        reason = RSN_BAD_STATE;
                CMD_SET_PWM:
                begin
                    if (tmo == 0)
                        tmo = int'(def_tmo);
                    if (r.pwm_channel >= Channels)
                        reason = RSN_BAD_CHANNEL;
                    else if (r.pwm_reserved != 0)
                        reason = RSN_INVALID;
                    else if (pw < int'(lim_min) || pw > int'(lim_max))
                        reason = RSN_BAD_PWM;
                    else if (tmo < 200 || tmo > 2000)
                        reason = RSN_INVALID;
                    else if (est)
                        reason = RSN_ESTOP;
                    else if (cur_mode != MODE_MANUAL)
                        reason = RSN_NOT_ARMED;
                    else if (test_ch != NO_CHANNEL && test_ch != r.pwm_channel)
                        reason = RSN_BUSY;
                    else
                    begin
                        test_ch = r.pwm_channel;
                        en_bits |= EN_MANUAL;
                    end
                end
                CMD_NEUTRAL:
                begin
                    clear_ctl();
                    neutralize();
                    if (!est && (cur_mode == MODE_MANUAL || cur_mode == MODE_ACTIVE))
                        chg = go_mode(MODE_IDLE);
                end
                CMD_FLOAT_ON:
                    if (!est && (cur_mode == MODE_IDLE || cur_mode == MODE_ACTIVE))
                    begin
                        en_bits |= EN_FLOAT | EN_CTL;
                        en_bits &= ~EN_MANUAL;
                        test_ch = NO_CHANNEL;
                        chg = go_mode(MODE_ACTIVE);
                    end
                    else
                        reason = RSN_BAD_STATE;
                CMD_FLOAT_OFF, CMD_ANGLE_OFF:
                    if (cur_mode == MODE_ACTIVE)
                    begin
                        mine = (r.req_type == CMD_FLOAT_OFF) ? EN_FLOAT : EN_ANGLE;
                        other = (r.req_type == CMD_FLOAT_OFF) ? EN_ANGLE : EN_FLOAT;
                        en_bits &= ~mine;
                        if ((en_bits & (other | EN_BODY)) == 0)
                        begin
                            en_bits &= ~EN_CTL;
                            neutralize();
                            chg = go_mode(MODE_IDLE);
                        end
                    end
                    else
                        reason = RSN_BAD_STATE;
                CMD_ANGLE_ON:
                    if (!est && (cur_mode == MODE_IDLE || cur_mode == MODE_ACTIVE))
                    begin
                        en_bits |= EN_ANGLE | EN_CTL;
                        chg = go_mode(MODE_ACTIVE);
                    end
                    else
                        reason = RSN_BAD_STATE;
                CMD_DEPTH:
                    if (!r.value_ok)
                        reason = RSN_INVALID;
                    else if (!(cur_mode == MODE_ACTIVE && (en_bits & (EN_BODY | EN_FLOAT)) != 0
                               && !est))
                        reason = RSN_BAD_STATE;
                CMD_YAW:
                    if (!r.value_ok)
                        reason = RSN_INVALID;
                    else if (cur_mode == MODE_ACTIVE && !est)
                        en_bits |= EN_ANGLE | EN_CTL;
                    else
                        reason = RSN_BAD_STATE;
                CMD_MOTION, CMD_BODY:
                begin
                    good = (r.req_type == CMD_MOTION) ? (r.motion_code <= 7) : r.value_ok;
                    if (r.req_type == CMD_MOTION)
                        ok = cur_mode == MODE_ACTIVE && (en_bits & EN_CTL) != 0
                             && (en_bits & (EN_FLOAT | EN_BODY)) != 0 && !est;
                    else
                        ok = cur_mode == MODE_ACTIVE && (en_bits & EN_BODY) != 0
                             && (en_bits & EN_CTL) != 0 && !est;
                    if (!good)
                    begin
                        chg = drop_motion();
                        reason = RSN_INVALID;
                    end
                    else if (!ok)
                    begin
                        chg = drop_motion();
                        reason = RSN_BAD_STATE;
                    end
                end
                CMD_BODY_ON:
                    if (!est && cur_mode == MODE_IDLE)
                    begin
                        en_bits |= EN_CTL | EN_BODY;
                        en_bits &= ~(EN_FLOAT | EN_ANGLE);
                        chg = go_mode(MODE_ACTIVE);
                    end
                    else
                        reason = est ? RSN_ESTOP : RSN_BAD_STATE;
                CMD_BODY_OFF:
                    if (cur_mode == MODE_ACTIVE && (en_bits & EN_BODY) != 0)
                    begin
                        en_bits &= ~(EN_CTL | EN_FLOAT | EN_ANGLE | EN_BODY);
                        chg = go_mode(MODE_IDLE);
                    end
                    else
                        reason = RSN_BAD_STATE;
                CMD_TUNING:
                    if (!r.value_ok)
                        reason = RSN_INVALID;
                    else if (est || !(cur_mode == MODE_DISARMED || cur_mode == MODE_IDLE))
                        reason = est ? RSN_ESTOP : RSN_BAD_STATE;
                CMD_STATUS:
                    kind = KIND_STATUS;
                default:
                    return 1'b0;
            endcase
        end
        if (reason >= 0)
        begin
            kind = KIND_NACK;
            if (err_cnt != 16'hFFFF)
                err_cnt++;
        end
        o.kind = kind;
        o.echo_sequence = r.sequence_req;
        o.nack_type = (reason >= 0) ? r.req_type : 5'd0;
        o.nack_reason = (reason >= 0) ? 4'(reason) : 4'd0;
        o.safety_mode = cur_mode;
        o.flags = (en_bits & 6'h2F) | (latched ? 6'h10 : 6'h00);
        o.test_chan = test_ch;
        o.nack_total = err_cnt;
        o.state_changed = chg;
        return 1'b1;
    endfunction

    function automatic req_t make_cmd(logic [4:0] t);
        req_t c;
        int   hi;
        c.req_type = t;
        c.sequence_req = 16'($urandom);
        c.now_ms = $urandom;
        c.payload_ok = 1'b1;
        c.value_ok = 1'b1;
        c.pwm_channel = 8'($urandom_range(0, Channels - 1));
        c.pwm_reserved = 8'd0;
        hi = (lim_max > 32767) ? 32767 : int'(lim_max);
        if (lim_min <= hi)
            c.pwm_us = 16'($urandom_range(int'(lim_min), hi));
        else
            c.pwm_us = 16'($urandom);
        c.pwm_timeout_ms = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(200, 2000));
        c.motion_code = 8'($urandom_range(0, 7));
        c.hb_window_ms = 16'($urandom_range(200, 5000));
        return c;
    endfunction

    function automatic req_t noisy_cmd(logic [4:0] t);
        req_t c;
        c = make_cmd(t);
        if ($urandom_range(0, 19) == 0) c.payload_ok = 1'b0;
        if ($urandom_range(0, 9) == 0) c.value_ok = 1'b0;
        if ($urandom_range(0, 11) == 0) c.pwm_channel = 8'($urandom);
        if ($urandom_range(0, 19) == 0) c.pwm_reserved = 8'($urandom);
        if ($urandom_range(0, 9) == 0) c.pwm_us = 16'($urandom);
        if ($urandom_range(0, 9) == 0) c.pwm_timeout_ms = 16'($urandom);
        if ($urandom_range(0, 9) == 0) c.motion_code = 8'($urandom);
        if ($urandom_range(0, 9) == 0) c.hb_window_ms = 16'($urandom);
        return c;
    endfunction

    task automatic push_random(int n);
        int k;
        int pick;
        k = 0;
        while (k < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                cmd_backlog.push_back(noisy_cmd(CMD_ARM));
                cmd_backlog.push_back(noisy_cmd(CMD_ENTER_MAN));
                repeat ($urandom_range(1, 4)) cmd_backlog.push_back(noisy_cmd(CMD_SET_PWM));
                cmd_backlog.push_back(noisy_cmd($urandom_range(0, 1) ? CMD_EXIT_MAN : CMD_NEUTRAL));
                k += 7;
            end
            else if (pick < 20)
            begin
                cmd_backlog.push_back(noisy_cmd(CMD_ARM));
                cmd_backlog.push_back(noisy_cmd(CMD_BODY_ON));
                repeat ($urandom_range(1, 4))
                    cmd_backlog.push_back(noisy_cmd($urandom_range(0, 1) ? CMD_BODY : CMD_MOTION));
                cmd_backlog.push_back(noisy_cmd(CMD_BODY_OFF));
                k += 7;
            end
            else if (pick < 30)
            begin
                cmd_backlog.push_back(noisy_cmd(CMD_ARM));
                cmd_backlog.push_back(noisy_cmd($urandom_range(0, 1) ? CMD_FLOAT_ON : CMD_ANGLE_ON));
                repeat ($urandom_range(1, 5))
                    cmd_backlog.push_back(noisy_cmd(5'($urandom_range(10, 17))));
                k += 7;
            end
            else if (pick < 34)
            begin
                cmd_backlog.push_back(noisy_cmd(CMD_ESTOP));
                cmd_backlog.push_back(noisy_cmd(5'($urandom_range(0, 23))));
                cmd_backlog.push_back(noisy_cmd(CMD_RESET_ESTOP));
                k += 3;
            end
            else if (pick < 38)
            begin
                cmd_backlog.push_back(noisy_cmd(5'($urandom_range(24, 31))));
                k++;
            end
            else
            begin
                cmd_backlog.push_back(noisy_cmd(5'($urandom_range(0, 23))));
                k++;
            end
        end
    endtask

    task automatic settle();
        do @(posedge clk);
        while (cmd_backlog.size() != 0 || req_ch.valid || answers_due.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_PWM_MIN: lim_min = val;
            CFG_PWM_MAX: lim_max = val;
            CFG_DEF_TMO: def_tmo = val & 16'h07FF;
            default: neutral_us = val;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic setup(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic [15:0] d);
        write_reg(CFG_PWM_MIN, a);
        write_reg(CFG_PWM_MAX, b);
        write_reg(CFG_DEF_TMO, c);
        write_reg(CFG_NEUTRAL, d);
    endtask

    task automatic report(string what, rsp_t got, rsp_t want);
        error_total++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t ans;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                if (predict_answer(req_ch.data, ans))
                    answers_due.push_back(ans);
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    req_ch.data <= cmd_backlog.pop_front();
                    req_ch.valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = flat_out ? 0 : $urandom_range(0, 6);
                    end
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    int stall_cyc = 0;
    always @(posedge clk)
    begin
        stall_cyc <= stall_cyc + 1;
        if (flat_out || (stall_cyc % 256) < 64)
            rsp_ch.ready <= 1'b1;
        else if ((stall_cyc % 23) < 5)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    // monitor
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (answers_due.size() == 0)
                report("unexpected word", rsp_ch.data, '0);
            else
            begin
                want = answers_due.pop_front();
                if (rsp_ch.data.kind !== want.kind) report("kind", rsp_ch.data, want);
                if (rsp_ch.data.echo_sequence !== want.echo_sequence)
                    report("echo_sequence", rsp_ch.data, want);
                if (rsp_ch.data.nack_type !== want.nack_type) report("nack_type", rsp_ch.data, want);
                if (rsp_ch.data.nack_reason !== want.nack_reason)
                    report("nack_reason", rsp_ch.data, want);
                if (rsp_ch.data.safety_mode !== want.safety_mode)
                    report("safety_mode", rsp_ch.data, want);
                if (rsp_ch.data.flags !== want.flags) report("flags", rsp_ch.data, want);
                if (rsp_ch.data.test_chan !== want.test_chan)
                    report("test_chan", rsp_ch.data, want);
                if (rsp_ch.data.nack_total !== want.nack_total)
                    report("nack_total", rsp_ch.data, want);
                if (rsp_ch.data.state_changed !== want.state_changed)
                    report("state_changed", rsp_ch.data, want);
            end
        end
    end

    initial
    begin
        req_t c;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        lim_min = 16'd1100;
        lim_max = 16'd1900;
        def_tmo = 16'd1000;
        neutral_us = 16'd1500;
        cur_mode = MODE_DISARMED;
        latched = 1'b0;
        en_bits = '0;
        test_ch = NO_CHANNEL;
        err_cnt = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        cmd_backlog.push_back(make_cmd(CMD_NOP));
        cmd_backlog.push_back(make_cmd(CMD_STATUS));
        c = make_cmd(CMD_HEARTBEAT); c.hb_window_ms = 16'd199; cmd_backlog.push_back(c);
        c.hb_window_ms = 16'd200; cmd_backlog.push_back(c);
        c.hb_window_ms = 16'd5001; cmd_backlog.push_back(c);
        c = make_cmd(5'd31); cmd_backlog.push_back(c);
        c = make_cmd(5'd24); c.payload_ok = 1'b0; cmd_backlog.push_back(c);
        cmd_backlog.push_back(make_cmd(CMD_SENSOR));
        cmd_backlog.push_back(make_cmd(CMD_TUNE_REQ));
        c = make_cmd(CMD_SENSOR); c.payload_ok = 1'b0; cmd_backlog.push_back(c);
        cmd_backlog.push_back(make_cmd(CMD_ARM));
        cmd_backlog.push_back(make_cmd(CMD_ENTER_MAN));
        c = make_cmd(CMD_SET_PWM); c.pwm_channel = 8'd7; c.pwm_us = 16'sd1900;
        c.pwm_timeout_ms = 16'd0; cmd_backlog.push_back(c);
        c.pwm_channel = 8'd2; cmd_backlog.push_back(c);
        c.pwm_channel = 8'd255; cmd_backlog.push_back(c);
        c.pwm_channel = 8'd7; c.pwm_reserved = 8'hFF; cmd_backlog.push_back(c);
        c.pwm_reserved = 8'd0; c.pwm_us = -16'sd32768; cmd_backlog.push_back(c);
        c.pwm_us = 16'sd1100; c.pwm_timeout_ms = 16'hFFFF; cmd_backlog.push_back(c);
        cmd_backlog.push_back(make_cmd(CMD_EXIT_MAN));
        cmd_backlog.push_back(make_cmd(CMD_FLOAT_ON));
        c = make_cmd(CMD_MOTION); c.motion_code = 8'hFF; cmd_backlog.push_back(c);
        cmd_backlog.push_back(make_cmd(CMD_BODY_ON));
        c = make_cmd(CMD_BODY); c.payload_ok = 1'b0; cmd_backlog.push_back(c);
        cmd_backlog.push_back(make_cmd(CMD_ESTOP));
        cmd_backlog.push_back(make_cmd(CMD_RESET_ESTOP));
        push_random(300);
        settle();

        setup(16'd0, 16'hFFFF, 16'd200, 16'd0);
        push_random(400);
        settle();
        setup(16'd2000, 16'd1000, 16'd2000, 16'hFFFF);
        push_random(300);
        settle();
        setup(16'd900, 16'd2100, 16'd1500, 16'd1450);
        push_random(350);
        settle();
        setup(16'($urandom_range(0, 2000)), 16'($urandom_range(1000, 65535)),
              16'($urandom_range(200, 2000)), 16'($urandom));
        push_random(350);
        settle();

        // full rate with no gaps and no receiver stalls
        flat_out = 1'b1;
        push_random(100);
        settle();
        flat_out = 1'b0;
        push_random(30);
        settle();

        if (error_total == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
